[rtl/fraction_gcd_reducer_assert.svh]
`ifndef FRACTION_GCD_REDUCER_ASSERT_SVH
`define FRACTION_GCD_REDUCER_ASSERT_SVH
// concurrent checks on clk with asynchronous reset
`define FGR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FGR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/fgr_pkg.sv]
package fgr_pkg;
	typedef enum logic [1:0] {
		OP_MOD,
		OP_DIVN,
		OP_DIVD
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} cell_ctl_t;
endpackage

[rtl/fgr_cell.sv]
module fgr_cell #(
	parameter int W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fgr_pkg::cell_ctl_t ctl,
	input  logic [W-1:0]       divisor,
	input  logic               next_bit,
	input  logic [W-1:0]       rem,
	output fgr_pkg::cell_ctl_t ctl_q,
	output logic [W-1:0]       rem_q,
	output logic               q_q
);
	logic [W:0] shifted;
	logic [W:0] trial;

	// one restoring step: bring in the next dividend bit and try the subtract
	assign shifted = {rem, next_bit};
	assign trial   = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			rem_q <= '0;
			q_q   <= 1'b0;
		end else begin
			ctl_q <= ctl;
			if (ctl.valid) begin
				rem_q <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
				q_q   <= ~trial[W];
			end
		end
	end
endmodule

[rtl/fgr_divider.sv]
module fgr_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  fgr_pkg::op_t op,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output fgr_pkg::op_t done_op,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	fgr_pkg::cell_ctl_t [W:0] ctl_c;
	logic [W:0][W-1:0]        rem_c;
	logic [W-1:0]             q_c;

	// dividend and divisor are held by the caller until done
	assign ctl_c[0] = {start, op};
	assign rem_c[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_chain
		fgr_cell #(.W(W)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl_c[i]), .divisor(divisor),
			.next_bit(dividend[W-1-i]), .rem(rem_c[i]),
			.ctl_q(ctl_c[i+1]), .rem_q(rem_c[i+1]), .q_q(q_c[W-1-i])
		);
	end

	assign done      = ctl_c[W].valid;
	assign done_op   = ctl_c[W].op;
	assign quotient  = q_c;
	assign remainder = rem_c[W];
endmodule

[rtl/fraction_gcd_reducer.sv]
// a zero denominator goes straight to the output; otherwise k remainder steps run,
// then the numerator and denominator are each divided by the gcd unless it is one;
// k is at most 45 at 32 bits; each step runs once down a chain of VALUE_WIDTH cells
// one word at a time: the next word is taken only after the result has left the
// output state, which it leaves only when the result is not stalled
// reset: asynchronous, active low; clears control, valid and output registers
`include "fraction_gcd_reducer_assert.svh"
module fraction_gcd_reducer #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] numerator,
	input  logic signed [VALUE_WIDTH-1:0] denominator,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] reduced_numerator,
	output logic signed [VALUE_WIDTH-1:0] reduced_denominator,
	output logic                          zero_denominator
);
	localparam int W = VALUE_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MOD, ST_DIVN, ST_DIVD, ST_OUT
	} state_t;

	state_t       state_q;
	fgr_pkg::op_t op_q;
	logic         launch_q;
	logic [W-1:0] num_q, den_q, dvd_q, dvs_q, qn_q;
	logic         div_done;
	fgr_pkg::op_t div_op;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;
	logic [2*W:0] out_word;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		mag = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	fgr_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(launch_q), .op(op_q),
		.dividend(dvd_q), .divisor(dvs_q), .done(div_done), .done_op(div_op),
		.quotient(div_quo), .remainder(div_rem)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign out_word = {reduced_numerator, reduced_denominator, zero_denominator};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			op_q                <= fgr_pkg::OP_MOD;
			launch_q            <= 1'b0;
			num_q               <= '0;
			den_q               <= '0;
			dvd_q               <= '0;
			dvs_q               <= '0;
			qn_q                <= '0;
			out_valid           <= 1'b0;
			reduced_numerator   <= '0;
			reduced_denominator <= '0;
			zero_denominator    <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						num_q <= numerator;
						den_q <= denominator;
						if (denominator == '0) begin
							reduced_numerator   <= numerator;
							reduced_denominator <= denominator;
							zero_denominator    <= 1'b1;
							out_valid           <= 1'b1;
							state_q             <= ST_OUT;
						end else begin
							dvd_q    <= mag(numerator);
							dvs_q    <= mag(denominator);
							op_q     <= fgr_pkg::OP_MOD;
							launch_q <= 1'b1;
							state_q  <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (div_done) begin
						if (div_rem != '0) begin
							// next remainder step, the divisor moves to the dividend
							dvd_q    <= dvs_q;
							dvs_q    <= div_rem;
							launch_q <= 1'b1;
						end else if (dvs_q == W'(1)) begin
							reduced_numerator   <= num_q;
							reduced_denominator <= den_q;
							zero_denominator    <= 1'b0;
							out_valid           <= 1'b1;
							state_q             <= ST_OUT;
						end else begin
							dvd_q    <= mag(num_q);
							op_q     <= fgr_pkg::OP_DIVN;
							launch_q <= 1'b1;
							state_q  <= ST_DIVN;
						end
					end
				end
				ST_DIVN: begin
					if (div_done) begin
						qn_q     <= div_quo;
						dvd_q    <= mag(den_q);
						op_q     <= fgr_pkg::OP_DIVD;
						launch_q <= 1'b1;
						state_q  <= ST_DIVD;
					end
				end
				ST_DIVD: begin
					if (div_done) begin
						reduced_numerator   <= num_q[W-1] ? (~qn_q + 1'b1) : qn_q;
						reduced_denominator <= den_q[W-1] ? (~div_quo + 1'b1) : div_quo;
						zero_denominator    <= 1'b0;
						out_valid           <= 1'b1;
						state_q             <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FGR_ASSERT_IMPL(a_valid_state, out_valid, state_q == ST_OUT, "valid outside output state")
	`FGR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word), "word changed")
	`FGR_ASSERT_IMPL(a_done_op, div_done, div_op == op_q, "chain result for another operation")
	`FGR_ASSERT_IMPL(a_zero_pass, out_valid && zero_denominator, reduced_denominator == '0, "bad flag")
endmodule
